// File: hdl/flow_table_with_aging_core_defines.svh
// Assertion macros for the flow table core.
`ifndef FLOW_TABLE_WITH_AGING_CORE_DEFINES_SVH
`define FLOW_TABLE_WITH_AGING_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define FT_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// invariant checked on every clock edge outside reset
`define FT_ASSERT_ALWAYS(label, clk, rst_n, a, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a)) else $error(msg);
`endif

// File: hdl/ft_pkg.sv
// Package: operation, kind and status codes and payload types of the flow table.
package ft_pkg;
    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_INS_AUTO = 3'd1,
        OP_INS_MAN = 3'd2,
        OP_DELETE = 3'd3,
        OP_TICK = 3'd4
    } op_t;
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_MODIFIED = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_DELETED = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [1:0] REG_AUTO_LIFETIME = 2'd0;
    localparam logic [1:0] REG_WARN_LEVEL = 2'd1;
    localparam logic [1:0] REG_SERVICE_PORT = 2'd2;
    typedef struct packed {
        logic [2:0] operation;
        logic [63:0] src_addr_high;
        logic [63:0] src_addr_low;
        logic [63:0] dst_addr_high;
        logic [63:0] dst_addr_low;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0] flow_action;
        logic [63:0] next_hop_id;
    } req_t;
    typedef struct packed {
        logic [1:0] kind;
        logic forward;
        logic [63:0] hop_out;
        logic [2:0] status;
        logic [7:0] report_src;
        logic [7:0] report_dst;
        logic last;
    } rsp_t;
    // one table entry as held in the entry memory
    typedef struct packed {
        logic [63:0] ksh;
        logic [63:0] ksl;
        logic [63:0] kdh;
        logic [63:0] kdl;
        logic [63:0] hop;
        logic [7:0] action;
        logic [15:0] life;
        logic perm;
    } entry_t;
endpackage

// File: hdl/ft_if.sv
// Valid/ready channel interfaces for requests and results.
interface ft_req_if;
    import ft_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ft_rsp_if;
    import ft_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/flow_table_with_aging_core.sv
// Top level: exact-match flow table with idle aging, one entry memory and a report stack.
// channel   dir   payload        transfer when
// req       in    ft_pkg::req_t  req.valid && req.ready
// rsp       out   ft_pkg::rsp_t  rsp.valid && rsp.ready
// cfg       in    index, data    cfg_we
// One operation at a time; no new request is taken until it is done. A search
// reads each entry from the entry memory (registered read) in S_RD and compares
// it in S_CMP, then lookup/insert/delete give their result, plus compaction for a delete.
// Delete and aging removal compact by copying each later entry down (S_SHIFT_RD, S_SHIFT_WR).
// Tick drains the report stack while rsp is taken; stalls on rsp hold the FSM.
// Reset clears counts and state, loads register defaults; memories need no clearing.
`include "flow_table_with_aging_core_defines.svh"
module flow_table_with_aging_core #(
    parameter int TABLE_DEPTH = 32,
    parameter int REPORT_DEPTH = 16
) (
    input logic clk,
    input logic rst_n,
    ft_req_if.sink req,
    ft_rsp_if.source rsp,
    input logic cfg_we,
    input logic [1:0] cfg_index,
    input logic [15:0] cfg_data
);
    import ft_pkg::*;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = (REPORT_DEPTH > 1) ? $clog2(REPORT_DEPTH) : 1;
    localparam int RCW = $clog2(REPORT_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CMP, S_SHIFT_RD, S_SHIFT_WR, S_AGE_RD, S_AGE_CMP,
        S_DRAIN_RD, S_DRAIN, S_OUT
    } state_t;

    state_t state_reg;
    req_t cur_reg;
    logic [15:0] auto_lifetime_reg, warn_level_reg, service_port_reg;
    logic [CW-1:0] count_reg;
    logic [RCW-1:0] rcount_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] age_idx_reg;
    logic age_reg;
    rsp_t out_reg;
    logic out_valid_reg;

    entry_t mem [TABLE_DEPTH];
    logic [15:0] rstack [REPORT_DEPTH];
    entry_t rd_data_reg;
    logic [15:0] rs_data_reg;

    logic mem_re, mem_we, rs_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    entry_t mem_wdata;
    logic [RW-1:0] rs_addr_w, rs_addr_r;
    logic [15:0] rs_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
        if (rs_we)
        begin
            rstack[rs_addr_w] <= rs_wdata;
        end
        rs_data_reg <= rstack[rs_addr_r];
    end

    logic key_hit;
    assign key_hit = rd_data_reg.ksh == cur_reg.src_addr_high
        && rd_data_reg.ksl == cur_reg.src_addr_low
        && rd_data_reg.kdh == cur_reg.dst_addr_high
        && rd_data_reg.kdl == cur_reg.dst_addr_low;

    logic out_free;
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;

    logic svc_hit;
    assign svc_hit = req.data.operation == OP_LOOKUP
        && (req.data.src_port == service_port_reg || req.data.dst_port == service_port_reg);
    logic out_set;
    assign out_set = (state_reg == S_IDLE && req.valid && req.ready && svc_hit)
        || ((state_reg == S_DRAIN || state_reg == S_OUT) && out_free);

    logic [AW-1:0] idx_a;
    assign idx_a = idx_reg[AW-1:0];
    logic rs_full;
    assign rs_full = rcount_reg == RCW'(REPORT_DEPTH);

    always_comb
    begin
        mem_re = 1'b0;
        mem_raddr = idx_a;
        mem_we = 1'b0;
        mem_waddr = idx_a;
        mem_wdata = rd_data_reg;
        rs_we = 1'b0;
        rs_addr_w = rcount_reg[RW-1:0];
        rs_addr_r = RW'(rcount_reg - RCW'(1));
        rs_wdata = {cur_reg.src_addr_low[7:0], cur_reg.dst_addr_low[7:0]};
        unique case (state_reg)
            S_RD, S_AGE_RD:
            begin
                mem_re = 1'b1;
            end
            S_SHIFT_RD:
            begin
                mem_re = 1'b1;
                mem_raddr = AW'(idx_reg + CW'(1));
            end
            S_SHIFT_WR:
            begin
                mem_we = 1'b1;
            end
            S_CMP:
            begin
                if (idx_reg == count_reg)
                begin
                    if (cur_reg.operation == OP_LOOKUP && !rs_full)
                    begin
                        rs_we = 1'b1;
                    end
                    if ((cur_reg.operation == OP_INS_AUTO || cur_reg.operation == OP_INS_MAN)
                        && count_reg != CW'(TABLE_DEPTH))
                    begin
                        mem_we = 1'b1;
                    end
                end
                else if (key_hit && (cur_reg.operation == OP_INS_AUTO
                    || cur_reg.operation == OP_INS_MAN))
                begin
                    mem_we = 1'b1;
                end
                mem_wdata.ksh = cur_reg.src_addr_high;
                mem_wdata.ksl = cur_reg.src_addr_low;
                mem_wdata.kdh = cur_reg.dst_addr_high;
                mem_wdata.kdl = cur_reg.dst_addr_low;
                mem_wdata.hop = cur_reg.next_hop_id;
                mem_wdata.action = cur_reg.flow_action;
                mem_wdata.perm = cur_reg.operation == OP_INS_MAN;
                mem_wdata.life = (cur_reg.operation == OP_INS_MAN) ? 16'd0 : auto_lifetime_reg;
            end
            S_AGE_CMP:
            begin
                if (!rd_data_reg.perm && rd_data_reg.life == warn_level_reg && !rs_full)
                begin
                    rs_we = 1'b1;
                    rs_wdata = {rd_data_reg.ksl[7:0], rd_data_reg.kdl[7:0]};
                end
                if (!rd_data_reg.perm && rd_data_reg.life > 16'd1)
                begin
                    mem_we = 1'b1;
                    mem_wdata.life = rd_data_reg.life - 16'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    function automatic rsp_t mk(logic [1:0] k, logic f, logic [63:0] h, logic [2:0] s,
                                logic [15:0] r, logic l);
        rsp_t o;
        o.kind = k;
        o.forward = f;
        o.hop_out = h;
        o.status = s;
        o.report_src = r[15:8];
        o.report_dst = r[7:0];
        o.last = l;
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg <= '0;
            out_reg <= '0;
            count_reg <= '0;
            rcount_reg <= '0;
            out_valid_reg <= 1'b0;
            auto_lifetime_reg <= 16'd900;
            warn_level_reg <= 16'd3;
            service_port_reg <= 16'd5683;
            idx_reg <= '0;
            age_idx_reg <= '0;
            age_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_AUTO_LIFETIME: auto_lifetime_reg <= cfg_data;
                    REG_WARN_LEVEL: warn_level_reg <= cfg_data;
                    REG_SERVICE_PORT: service_port_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        cur_reg <= req.data;
                        idx_reg <= '0;
                        if (svc_hit)
                        begin
                            out_reg <= mk(KIND_LOOKUP, 1'b0, '0, '0, '0, 1'b1);
                        end
                        else if (req.data.operation == OP_TICK)
                        begin
                            age_reg <= 1'b1;
                            state_reg <= (count_reg == '0) ? S_DRAIN_RD : S_AGE_RD;
                        end
                        else if (req.data.operation <= OP_DELETE)
                        begin
                            age_reg <= 1'b0;
                            state_reg <= (count_reg == '0) ? S_CMP : S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (idx_reg == count_reg)
                    begin
                        state_reg <= S_OUT;
                        priority case (cur_reg.operation)
                            OP_LOOKUP:
                            begin
                                if (!rs_full)
                                begin
                                    rcount_reg <= rcount_reg + RCW'(1);
                                end
                                out_reg <= mk(KIND_LOOKUP, 1'b0, '0, '0, '0, 1'b1);
                            end
                            OP_DELETE:
                            begin
                                out_reg <= mk(KIND_UPDATE, 1'b0, '0, ST_NOT_FOUND, '0, 1'b1);
                            end
                            default:
                            begin
                                if (count_reg == CW'(TABLE_DEPTH))
                                begin
                                    out_reg <= mk(KIND_UPDATE, 1'b0, '0, ST_FULL, '0, 1'b1);
                                end
                                else
                                begin
                                    count_reg <= count_reg + CW'(1);
                                    out_reg <= mk(KIND_UPDATE, 1'b0, '0, ST_INSERTED, '0, 1'b1);
                                end
                            end
                        endcase
                    end
                    else if (key_hit)
                    begin
                        priority case (cur_reg.operation)
                            OP_LOOKUP:
                            begin
                                state_reg <= S_OUT;
                                out_reg <= (rd_data_reg.action == 8'd0)
                                    ? mk(KIND_LOOKUP, 1'b1, rd_data_reg.hop, '0, '0, 1'b1)
                                    : mk(KIND_LOOKUP, 1'b0, '0, '0, '0, 1'b1);
                            end
                            OP_DELETE:
                            begin
                                out_reg <= mk(KIND_UPDATE, 1'b0, '0, ST_DELETED, '0, 1'b1);
                                state_reg <= S_SHIFT_RD;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                                out_reg <= mk(KIND_UPDATE, 1'b0, '0, ST_MODIFIED, '0, 1'b1);
                            end
                        endcase
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= (idx_reg + CW'(1) == count_reg) ? S_CMP : S_RD;
                    end
                end
                S_SHIFT_RD:
                begin
                    if (idx_reg + CW'(1) >= count_reg)
                    begin
                        count_reg <= count_reg - CW'(1);
                        if (age_reg)
                        begin
                            // resume aging at the slot the next entry moved into
                            idx_reg <= age_idx_reg;
                            state_reg <= (age_idx_reg + CW'(1) >= count_reg)
                                ? S_DRAIN_RD : S_AGE_RD;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    state_reg <= S_SHIFT_RD;
                end
                S_AGE_RD:
                begin
                    state_reg <= S_AGE_CMP;
                end
                S_AGE_CMP:
                begin
                    if (!rd_data_reg.perm && rd_data_reg.life == warn_level_reg && !rs_full)
                    begin
                        rcount_reg <= rcount_reg + RCW'(1);
                    end
                    if (!rd_data_reg.perm && rd_data_reg.life <= 16'd1)
                    begin
                        age_idx_reg <= idx_reg;
                        state_reg <= S_SHIFT_RD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= (idx_reg + CW'(1) >= count_reg) ? S_DRAIN_RD : S_AGE_RD;
                    end
                end
                S_DRAIN_RD:
                begin
                    if (rcount_reg == '0)
                    begin
                        out_reg <= mk(KIND_EMPTY, 1'b0, '0, '0, '0, 1'b1);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (out_free)
                    begin
                        out_reg <= mk(KIND_REPORT, 1'b0, '0, '0, rs_data_reg,
                                      rcount_reg == RCW'(1));
                        rcount_reg <= rcount_reg - RCW'(1);
                        state_reg <= (rcount_reg == RCW'(1)) ? S_IDLE : S_DRAIN_RD;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `FT_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(TABLE_DEPTH), "entry count overflow")
    `FT_ASSERT_ALWAYS(a_rcount_range, clk, rst_n, rcount_reg <= RCW'(REPORT_DEPTH), "report count overflow")
    `FT_ASSERT_IMP(a_no_rw_clash, clk, rst_n, mem_we, !mem_re, "entry memory read and write together")
    `FT_ASSERT_IMP(a_busy_no_accept, clk, rst_n, state_reg != S_IDLE, !req.ready, "accept while busy")
endmodule

// File: tb/flow_table_with_aging_core_tb.sv
// Testbench for the flow table core: directed table plus random traffic against a predictor.
`timescale 1ns / 100ps
module flow_table_with_aging_core_tb;
    import ft_pkg::*;

    localparam int DEPTH = 32;
    localparam int RPT_DEPTH = 16;
    localparam int KEY_POOL = 40;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [2:0] OP_BAD_FIRST = 3'd5;
    localparam logic [2:0] OP_BAD_LAST = 3'd7;

    typedef struct packed {
        logic [63:0] sh;
        logic [63:0] sl;
        logic [63:0] dh;
        logic [63:0] dl;
    } flow_key_t;

    typedef struct {
        req_t item;
        bit typed;
        rsp_t result;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    ft_req_if req_ch ();
    ft_rsp_if rsp_ch ();

    flow_table_with_aging_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch.sink),
        .rsp(rsp_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0] lifetime_reg;
    logic [15:0] warn_reg;
    logic [15:0] svc_port_reg;
    flow_key_t flow_key [DEPTH];
    logic [63:0] flow_hop [DEPTH];
    logic [7:0] flow_act [DEPTH];
    logic [15:0] flow_life [DEPTH];
    bit flow_perm [DEPTH];
    int flow_cnt;
    logic [15:0] miss_stack [RPT_DEPTH];
    int miss_cnt;

    rsp_t pending_rsp [$];
    flow_key_t key_pool [KEY_POOL];
    row_t dir_rows [$];
    int errors;
    bit quiet;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    function automatic rsp_t mk_rsp(logic [1:0] kind, logic fwd, logic [63:0] hop,
                                    logic [2:0] st, logic [7:0] rs, logic [7:0] rd,
                                    logic lst);
        rsp_t r;
        r.kind = kind;
        r.forward = fwd;
        r.hop_out = hop;
        r.status = st;
        r.report_src = rs;
        r.report_dst = rd;
        r.last = lst;
        return r;
    endfunction

    function automatic flow_key_t key_of(req_t q);
        flow_key_t k;
        k.sh = q.src_addr_high;
        k.sl = q.src_addr_low;
        k.dh = q.dst_addr_high;
        k.dl = q.dst_addr_low;
        return k;
    endfunction

    function automatic int find_flow(flow_key_t k);
        for (int i = 0; i < flow_cnt; i++)
        begin
            if (flow_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic void push_miss(logic [63:0] sl, logic [63:0] dl);
        if (miss_cnt < RPT_DEPTH)
        begin
            miss_stack[miss_cnt] = {sl[7:0], dl[7:0]};
            miss_cnt++;
        end
    endfunction

    function automatic void drop_flow(int idx);
        for (int i = idx; i + 1 < flow_cnt; i++)
        begin
            flow_key[i] = flow_key[i + 1];
            flow_hop[i] = flow_hop[i + 1];
            flow_act[i] = flow_act[i + 1];
            flow_life[i] = flow_life[i + 1];
            flow_perm[i] = flow_perm[i + 1];
        end
        flow_cnt--;
    endfunction

    // updates the table and returns the results one request causes
    function automatic void table_step(req_t q, ref rsp_t res [$]);
        int idx;
        int i;
        flow_key_t k;
        logic [15:0] top;
        k = key_of(q);
        res = {};
        case (q.operation)
            OP_LOOKUP:
            begin
                if (q.src_port == svc_port_reg || q.dst_port == svc_port_reg)
                    res.push_back(mk_rsp(KIND_LOOKUP, 0, 0, 0, 0, 0, 1));
                else
                begin
                    idx = find_flow(k);
                    if (idx < 0)
                    begin
                        push_miss(k.sl, k.dl);
                        res.push_back(mk_rsp(KIND_LOOKUP, 0, 0, 0, 0, 0, 1));
                    end
                    else if (flow_act[idx] == 0)
                        res.push_back(mk_rsp(KIND_LOOKUP, 1, flow_hop[idx], 0, 0, 0, 1));
                    else
                        res.push_back(mk_rsp(KIND_LOOKUP, 0, 0, 0, 0, 0, 1));
                end
            end
            OP_INS_AUTO, OP_INS_MAN:
            begin
                idx = find_flow(k);
                if (idx < 0 && flow_cnt >= DEPTH)
                    res.push_back(mk_rsp(KIND_UPDATE, 0, 0, ST_FULL, 0, 0, 1));
                else
                begin
                    if (idx < 0)
                    begin
                        idx = flow_cnt;
                        flow_key[idx] = k;
                        flow_cnt++;
                        res.push_back(mk_rsp(KIND_UPDATE, 0, 0, ST_INSERTED, 0, 0, 1));
                    end
                    else
                        res.push_back(mk_rsp(KIND_UPDATE, 0, 0, ST_MODIFIED, 0, 0, 1));
                    flow_act[idx] = q.flow_action;
                    flow_hop[idx] = q.next_hop_id;
                    flow_perm[idx] = (q.operation == OP_INS_MAN);
                    flow_life[idx] = (q.operation == OP_INS_MAN) ? 16'd0 : lifetime_reg;
                end
            end
            OP_DELETE:
            begin
                idx = find_flow(k);
                if (idx < 0)
                    res.push_back(mk_rsp(KIND_UPDATE, 0, 0, ST_NOT_FOUND, 0, 0, 1));
                else
                begin
                    drop_flow(idx);
                    res.push_back(mk_rsp(KIND_UPDATE, 0, 0, ST_DELETED, 0, 0, 1));
                end
            end
            OP_TICK:
            begin
                i = 0;
                while (i < flow_cnt)
                begin
                    if (flow_perm[i])
                        i++;
                    else
                    begin
                        if (flow_life[i] == warn_reg)
                            push_miss(flow_key[i].sl, flow_key[i].dl);
                        if (flow_life[i] <= 1)
                            drop_flow(i);
                        else
                        begin
                            flow_life[i] = flow_life[i] - 16'd1;
                            i++;
                        end
                    end
                end
                if (miss_cnt == 0)
                    res.push_back(mk_rsp(KIND_EMPTY, 0, 0, 0, 0, 0, 1));
                while (miss_cnt > 0)
                begin
                    miss_cnt--;
                    top = miss_stack[miss_cnt];
                    res.push_back(mk_rsp(KIND_REPORT, 0, 0, 0, top[15:8], top[7:0],
                                         miss_cnt == 0));
                end
            end
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_rsp.size() == 0)
            begin
                $display("%t unexpected result: expected none, actual %p", $realtime, got);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got.kind !== want.kind)
                    $display("%t kind: expected %0d, actual %0d", $realtime, want.kind, got.kind);
                if (got.forward !== want.forward)
                    $display("%t forward: expected %0d, actual %0d", $realtime, want.forward,
                             got.forward);
                if (got.hop_out !== want.hop_out)
                    $display("%t hop_out: expected %h, actual %h", $realtime, want.hop_out,
                             got.hop_out);
                if (got.status !== want.status)
                    $display("%t status: expected %0d, actual %0d", $realtime, want.status,
                             got.status);
                if (got.report_src !== want.report_src)
                    $display("%t report_src: expected %h, actual %h", $realtime,
                             want.report_src, got.report_src);
                if (got.report_dst !== want.report_dst)
                    $display("%t report_dst: expected %h, actual %h", $realtime,
                             want.report_dst, got.report_dst);
                if (got.last !== want.last)
                    $display("%t last: expected %0d, actual %0d", $realtime, want.last, got.last);
                if (got !== want)
                    errors++;
            end
        end
    end

    // result-side stalls
    always @(negedge clk)
    begin
        int stall;
        if (quiet || !rst_n)
            rsp_ch.ready = 1'b1;
        else if (stall > 0)
        begin
            rsp_ch.ready = 1'b0;
            stall--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rsp_ch.ready = 1'b0;
            stall = $urandom_range(0, 2);
        end
        else
            rsp_ch.ready = 1'b1;
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(req_t q, bit typed, rsp_t typed_rsp);
        rsp_t res [$];
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data = q;
        do
            @(posedge clk);
        while (!req_ch.ready);
        table_step(q, res);
        if (typed)
            res = '{typed_rsp};
        foreach (res[i])
            pending_rsp.push_back(res[i]);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            REG_AUTO_LIFETIME: lifetime_reg = val;
            REG_WARN_LEVEL: warn_reg = val;
            REG_SERVICE_PORT: svc_port_reg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic req_t mk_req(logic [2:0] op, flow_key_t k, logic [15:0] sp,
                                    logic [15:0] dp, logic [7:0] act, logic [63:0] hop);
        req_t q;
        q.operation = op;
        q.src_addr_high = k.sh;
        q.src_addr_low = k.sl;
        q.dst_addr_high = k.dh;
        q.dst_addr_low = k.dl;
        q.src_port = sp;
        q.dst_port = dp;
        q.flow_action = act;
        q.next_hop_id = hop;
        return q;
    endfunction

    function automatic void add_row(req_t q, bit typed, rsp_t r);
        row_t w;
        w.item = q;
        w.typed = typed;
        w.result = r;
        dir_rows.push_back(w);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic flow_key_t rand_key();
        flow_key_t k;
        k.sh = rand64();
        k.sl = rand64();
        k.dh = rand64();
        k.dl = rand64();
        return k;
    endfunction

    // random phase: percentages for lookup, auto insert, manual insert, delete, tick
    task automatic random_phase(int items, int p_look, int p_auto, int p_man, int p_del,
                                int p_tick, int quiet_tail);
        int roll;
        logic [2:0] op;
        flow_key_t k;
        logic [15:0] sp;
        logic [15:0] dp;
        req_t q;
        rsp_t none;
        none = '0;
        for (int n = 0; n < items; n++)
        begin
            if (n == items - quiet_tail)
                quiet = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < p_look)
                op = OP_LOOKUP;
            else if (roll < p_look + p_auto)
                op = OP_INS_AUTO;
            else if (roll < p_look + p_auto + p_man)
                op = OP_INS_MAN;
            else if (roll < p_look + p_auto + p_man + p_del)
                op = OP_DELETE;
            else if (roll < p_look + p_auto + p_man + p_del + p_tick)
                op = OP_TICK;
            else
                op = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
            k = ($urandom_range(0, 4) == 0) ? rand_key() : key_pool[$urandom_range(0, KEY_POOL - 1)];
            sp = 16'($urandom);
            dp = 16'($urandom);
            case ($urandom_range(0, 9))
                0: sp = svc_port_reg;
                1: dp = svc_port_reg;
                default: ;
            endcase
            q = mk_req(op, k, sp, dp, ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom),
                       rand64());
            send_item(q, 1'b0, none);
        end
    endtask

    initial
    begin
        flow_key_t ka;
        flow_key_t kz;
        rsp_t none;
        logic [63:0] hop_x;
        errors = 0;
        quiet = 1'b0;
        none = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        lifetime_reg = 16'd900;
        warn_reg = 16'd3;
        svc_port_reg = 16'd5683;
        flow_cnt = 0;
        miss_cnt = 0;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = rand_key();
        ka = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        kz = '{64'd0, 64'd0, 64'd0, 64'd0};
        key_pool[0] = ka;
        key_pool[1] = kz;
        hop_x = 64'hA5A5_0F0F_3C3C_9696;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_row(mk_req(OP_TICK, kz, 0, 0, 0, 0), 1,
                mk_rsp(KIND_EMPTY, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(OP_LOOKUP, ka, 16'hFFFF, 16'hFFFF, 0, 0), 1,
                mk_rsp(KIND_LOOKUP, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(OP_DELETE, ka, 0, 0, 0, 0), 1,
                mk_rsp(KIND_UPDATE, 0, 0, ST_NOT_FOUND, 0, 0, 1));
        add_row(mk_req(OP_INS_AUTO, ka, 0, 0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF), 1,
                mk_rsp(KIND_UPDATE, 0, 0, ST_INSERTED, 0, 0, 1));
        add_row(mk_req(OP_LOOKUP, ka, 1, 2, 0, 0), 1,
                mk_rsp(KIND_LOOKUP, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 1));
        add_row(mk_req(OP_INS_AUTO, ka, 0, 0, 8'hFF, hop_x), 1,
                mk_rsp(KIND_UPDATE, 0, 0, ST_MODIFIED, 0, 0, 1));
        add_row(mk_req(OP_LOOKUP, ka, 1, 2, 0, 0), 1,
                mk_rsp(KIND_LOOKUP, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(OP_INS_MAN, ka, 0, 0, 8'd0, hop_x), 1,
                mk_rsp(KIND_UPDATE, 0, 0, ST_MODIFIED, 0, 0, 1));
        add_row(mk_req(OP_LOOKUP, ka, 0, 0, 0, 0), 1,
                mk_rsp(KIND_LOOKUP, 1, hop_x, 0, 0, 0, 1));
        add_row(mk_req(OP_LOOKUP, ka, 16'd5683, 0, 0, 0), 1,
                mk_rsp(KIND_LOOKUP, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(OP_LOOKUP, kz, 0, 16'd5683, 0, 0), 1,
                mk_rsp(KIND_LOOKUP, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(OP_INS_MAN, kz, 0, 0, 8'd1, 64'd0), 1,
                mk_rsp(KIND_UPDATE, 0, 0, ST_INSERTED, 0, 0, 1));
        add_row(mk_req(OP_TICK, kz, 0, 0, 0, 0), 1,
                mk_rsp(KIND_REPORT, 0, 0, 0, 8'hFF, 8'hFF, 1));
        add_row(mk_req(OP_LOOKUP, kz, 0, 0, 0, 0), 1,
                mk_rsp(KIND_LOOKUP, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(OP_INS_AUTO, key_pool[2], 0, 0, 8'd0, rand64()), 0, none);
        add_row(mk_req(OP_DELETE, ka, 0, 0, 0, 0), 1,
                mk_rsp(KIND_UPDATE, 0, 0, ST_DELETED, 0, 0, 1));
        add_row(mk_req(OP_LOOKUP, ka, 0, 0, 0, 0), 0, none);
        add_row(mk_req(OP_LOOKUP, key_pool[2], 0, 0, 0, 0), 0, none);
        for (logic [3:0] op = OP_BAD_FIRST; op <= OP_BAD_LAST; op++)
            add_row(mk_req(op[2:0], ka, 0, 0, 0, 0), 0, none);
        add_row(mk_req(OP_TICK, kz, 0, 0, 0, 0), 0, none);
        add_row(mk_req(OP_DELETE, kz, 0, 0, 0, 0), 0, none);
        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);

        // short lives: warn at the last tick, fast removal
        wait_idle();
        write_reg(REG_AUTO_LIFETIME, 16'd2);
        write_reg(REG_WARN_LEVEL, 16'd1);
        write_reg(REG_SERVICE_PORT, 16'd0);
        random_phase(80, 30, 30, 5, 10, 20, 0);

        // fill the table past full, miss often to overflow the report stack
        wait_idle();
        write_reg(REG_AUTO_LIFETIME, 16'd5);
        write_reg(REG_WARN_LEVEL, 16'd3);
        write_reg(REG_SERVICE_PORT, 16'hFFFF);
        random_phase(90, 35, 40, 15, 3, 5, 0);

        wait_idle();
        write_reg(REG_AUTO_LIFETIME, 16'hFFFF);
        write_reg(REG_WARN_LEVEL, 16'hFFFF);
        write_reg(REG_SERVICE_PORT, 16'($urandom));
        random_phase(80, 30, 20, 10, 20, 15, 0);

        wait_idle();
        write_reg(REG_AUTO_LIFETIME, 16'd3);
        write_reg(REG_WARN_LEVEL, 16'd2);
        write_reg(REG_SERVICE_PORT, 16'd5683);
        random_phase(140, 30, 25, 8, 15, 17, 50);

        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// File: flow_table_with_aging_core.f
+incdir+hdl
hdl/ft_pkg.sv
hdl/ft_if.sv
hdl/flow_table_with_aging_core.sv
tb/flow_table_with_aging_core_tb.sv
